// ===== sv/iira_pkg.sv =====
package iira_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             wr;
    logic             rd;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== sv/iira_cell.sv =====
module iira_cell #(
  parameter int DEPTH     = iira_pkg::DEPTH_DEF,
  parameter int WORD_BITS = iira_pkg::WORD_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  iira_pkg::cell_ctrl_t ctrl_i,
  input  logic [WORD_BITS-1:0] val_i,
  input  logic [WORD_BITS-1:0] lo_i,
  input  logic [WORD_BITS-1:0] hi_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] rd_o
);
  import iira_pkg::*;

  localparam int IDXW = $clog2(DEPTH);
  localparam int IW   = (POS_W > IDXW) ? POS_W : IDXW;
  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;
  logic [IW-1:0]        pos_x;
  logic                 hit, above;

  assign pos_x = IW'(ctrl_i.pos);
  assign hit   = (MyIdx == pos_x);
  assign above = (MyIdx > pos_x);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins && above) begin
      word_d = lo_i;
    end else if ((ctrl_i.ins || ctrl_i.wr) && hit) begin
      word_d = val_i;
    end else if (ctrl_i.rem && (hit || above)) begin
      word_d = hi_i;
    end
  end

  assign rd_d = (ctrl_i.rd && hit) ? word_q : '0;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rd_q   <= rd_d;
  end

  assign word_o = word_q;
  assign rd_o   = rd_q;

endmodule

// ===== sv/indexed_insert_remove_array_unit.sv =====
// Bounded ordered array with indexed insert/remove, read, write and clear.
// Request channel: kind_i, position_i, value_i, taken at a rising edge with
//   start_i high and busy_o low. busy_o stays low: one request per cycle.
// Result channel: status_o, read_value_o, count_o, valid for the single
//   cycle in which done_o is high; that cycle immediately follows the
//   request, and throughput is 1 request per cycle.
// Each word sits in its own cell; an insert shifts the cells above the
//   position, a remove those at and above it, one place, in the same cycle.
//   A read latches the addressed word in its cell and the cells' read
//   registers are OR-combined onto read_value_o in the result cycle.
// status_o: ok, index out of range, or array full (insert only; a bad
//   index is reported first). Errors leave the array unchanged.
// Reset (rst_ni low, asynchronous) empties the array and clears done_o; the
//   words themselves are not cleared and need no sweep. The receiver cannot
//   stall; a result not sampled in its cycle is gone.
module indexed_insert_remove_array_unit #(
  parameter int DEPTH     = iira_pkg::DEPTH_DEF,
  parameter int WORD_BITS = iira_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [iira_pkg::KIND_W-1:0]    kind_i,
  input  logic [iira_pkg::POS_W-1:0]     position_i,
  input  logic [iira_pkg::VAL_W-1:0]     value_i,
  output logic                           done_o,
  output logic [iira_pkg::STATUS_W-1:0]  status_o,
  output logic [iira_pkg::VAL_W-1:0]     read_value_o,
  output logic [iira_pkg::CNT_W-1:0]     count_o
);
  import iira_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (POS_W > CW) ? POS_W : CW;

  logic [CW-1:0]       count_q, count_d;
  logic                done_q;
  status_e             status_q, status_d;
  cell_ctrl_t          ctrl;
  logic [PW-1:0]       pos_x, cnt_x;
  logic                in_range, ins_range, full;
  logic [WORD_BITS-1:0] val_w;
  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] rds   [DEPTH];
  logic [WORD_BITS-1:0] rd_or;

  assign busy_o    = 1'b0;
  assign pos_x     = PW'(position_i);
  assign cnt_x     = PW'(count_q);
  assign in_range  = (pos_x < cnt_x);
  assign ins_range = (pos_x <= cnt_x);
  assign full      = (count_q == CW'(DEPTH));
  assign val_w     = WORD_BITS'(value_i);

  always_comb begin
    ctrl     = '0;
    ctrl.pos = position_i;
    status_d = ST_OK;
    count_d  = count_q;
    if (start_i) begin
      case (kind_i)
        KIND_INSERT: begin
          if (!ins_range) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            ctrl.rem = 1'b1;
            count_d  = count_q - CW'(1);
          end
        end
        KIND_READ: begin
          if (!in_range) status_d = ST_RANGE;
          else ctrl.rd = 1'b1;
        end
        KIND_WRITE: begin
          if (!in_range) status_d = ST_RANGE;
          else ctrl.wr = 1'b1;
        end
        KIND_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo, hi;
    if (i == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_hitop
      assign hi = '0;
    end else begin : g_hi
      assign hi = words[i+1];
    end
    iira_cell #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .val_i  (val_w),
      .lo_i   (lo),
      .hi_i   (hi),
      .word_o (words[i]),
      .rd_o   (rds[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | rds[i];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = VAL_W'(rd_or);
  assign count_o      = CNT_W'(count_q);

endmodule

// ===== sv/iira_chk.sv =====
module iira_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [iira_pkg::KIND_W-1:0]    kind_i,
  input logic [iira_pkg::POS_W-1:0]     position_i,
  input logic [iira_pkg::VAL_W-1:0]     value_i,
  input logic                           done_o,
  input logic [iira_pkg::STATUS_W-1:0]  status_o,
  input logic [iira_pkg::VAL_W-1:0]     read_value_o,
  input logic [iira_pkg::CNT_W-1:0]     count_o
);
  import iira_pkg::*;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(start_i && !busy_o)))
    else $error("result strobe does not match request");

  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_RANGE || status_o == ST_FULL)) |->
      (count_o == $past(count_o)))
    else $error("count changed on an error");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (read_value_o == '0))
    else $error("read data on an error");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_CLEAR) |=>
      (done_o && status_o == ST_OK && count_o == '0))
    else $error("clear did not empty the array");

endmodule

bind indexed_insert_remove_array_unit iira_chk u_iira_chk (.*);
